>>> sv/two_runway_queue_scheduler_macros.svh
// Assertion macros shared by the scheduler's modules.
`ifndef TWO_RUNWAY_QUEUE_SCHEDULER_MACROS_SVH
`define TWO_RUNWAY_QUEUE_SCHEDULER_MACROS_SVH

// A property checked at every rising edge outside reset.
`define TRQS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// A condition that must bring the given consequence in the next cycle.
`define TRQS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> sv/trqs_pkg.sv
// Types and constants of the two-runway queue scheduler.
`default_nettype none

package trqs_pkg;

    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int TAG_BITS_DEF     = 16;
    localparam int COUNTER_BITS_DEF = 32;

    localparam int TIME_BITS   = 32;
    localparam int FLIGHT_BITS = 16;
    localparam int LIMIT_W     = 5;
    localparam int COUNT_W     = 5;
    localparam int SEL_W       = 4;
    localparam int OUT_CNT_W   = 32;
    localparam int NUM_CNT     = 12;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    // Statistics counter indexes.
    localparam logic [SEL_W-1:0] CNT_LAND_REQ     = 4'd0;
    localparam logic [SEL_W-1:0] CNT_TAKEOFF_REQ  = 4'd1;
    localparam logic [SEL_W-1:0] CNT_LANDINGS     = 4'd2;
    localparam logic [SEL_W-1:0] CNT_TAKEOFFS     = 4'd3;
    localparam logic [SEL_W-1:0] CNT_LAND_ACC     = 4'd4;
    localparam logic [SEL_W-1:0] CNT_TAKEOFF_ACC  = 4'd5;
    localparam logic [SEL_W-1:0] CNT_LAND_REF     = 4'd6;
    localparam logic [SEL_W-1:0] CNT_TAKEOFF_REF  = 4'd7;
    localparam logic [SEL_W-1:0] CNT_LAND_WAIT    = 4'd8;
    localparam logic [SEL_W-1:0] CNT_TAKEOFF_WAIT = 4'd9;
    localparam logic [SEL_W-1:0] CNT_LAND_IDLE    = 4'd10;
    localparam logic [SEL_W-1:0] CNT_TAKEOFF_IDLE = 4'd11;

    typedef enum logic [1:0] {
        REQ_LAND    = 2'd0,
        REQ_TAKEOFF = 2'd1,
        REQ_TICK    = 2'd2,
        REQ_READ    = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_REFUSED  = 2'd1,
        ST_TICK     = 2'd2,
        ST_READ     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POP2
    } t_state;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_cmd;

    typedef struct packed {
        t_status                status;
        logic                   r1_valid;
        logic [FLIGHT_BITS-1:0] r1_tag;
        logic [TIME_BITS-1:0]   r1_wait;
        logic                   r2_valid;
        logic                   r2_is_landing;
        logic [FLIGHT_BITS-1:0] r2_tag;
        logic [TIME_BITS-1:0]   r2_wait;
        logic                   emergency;
        logic [COUNT_W-1:0]     landing_count;
        logic [COUNT_W-1:0]     takeoff_count;
        logic [OUT_CNT_W-1:0]   counter_value;
    } t_result;

endpackage

`default_nettype wire

>>> sv/trqs_fifo.sv
// Circular queue held in a synchronous memory, with the head entry always read out.
`default_nettype none
`include "two_runway_queue_scheduler_macros.svh"

module trqs_fifo
    import trqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ENTRY_BITS  = TAG_BITS_DEF + TIME_BITS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire t_fifo_cmd                          i_cmd,
    input  wire logic [ENTRY_BITS-1:0]              i_wdata,
    output logic      [ENTRY_BITS-1:0]              o_rdata,
    output logic      [$clog2(QUEUE_DEPTH+1)-1:0]   o_fill
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    logic [ENTRY_BITS-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]      r_head, n_head;
    logic [PTR_W-1:0]      r_tail, n_tail;
    logic [FILL_W-1:0]     r_fill, n_fill;
    logic [ENTRY_BITS-1:0] r_rdata;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_fill = r_fill;
        if (i_cmd.pop) begin
            n_head = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + PTR_W'(1);
        end
        if (i_cmd.push) begin
            n_tail = (r_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + PTR_W'(1);
        end
        n_fill = r_fill + FILL_W'(i_cmd.push) - FILL_W'(i_cmd.pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
        end
    end

    // The read address follows the next head, so the read register holds the entry at
    // the current head; a write into the head slot at the same edge is not yet seen.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[r_tail] <= i_wdata;
        end
        r_rdata <= mem[n_head];
    end

    assign o_rdata = r_rdata;
    assign o_fill  = r_fill;

    `TRQS_ASSERT(a_pop_not_empty, i_cmd.pop |-> (r_fill != '0), "pop from an empty queue")
    `TRQS_ASSERT(a_push_not_full, i_cmd.push |-> (r_fill < FILL_W'(QUEUE_DEPTH)), "push to a full queue")
    `TRQS_ASSERT_NEXT(a_fill_holds, !i_cmd.push && !i_cmd.pop, $stable(r_fill), "fill moved without a command")

endmodule

`default_nettype wire

>>> sv/two_runway_queue_scheduler.sv
// Two-runway queue scheduler: landing and takeoff queues, runway service and statistics.
// A request, a counter read or a normal tick passes from the input transfer to the
// execution state, which loads its result into the output register. An emergency tick
// passes through the execution state and a second pop state: each queue memory delivers
// one head entry per cycle, so its two landings are popped in consecutive cycles and the
// second pop state loads the result. The next input is taken once the current item
// has left for the output register; each execution cycle waits while an earlier
// result still sits there unaccepted. The queue memories need no clearing pass after
// reset. A new queue limit applies to every item that executes after the write, so
// write it only while nothing is in flight.
`default_nettype none
`include "two_runway_queue_scheduler_macros.svh"

module two_runway_queue_scheduler
    import trqs_pkg::*;
#(
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int TAG_BITS     = TAG_BITS_DEF,
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [LIMIT_W-1:0]     i_cfg_data,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [1:0]             i_req_type,
    input  wire logic [FLIGHT_BITS-1:0] i_flight_tag,
    input  wire logic [TIME_BITS-1:0]   i_time_now,
    input  wire logic [SEL_W-1:0]       i_counter_select,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [1:0]                  o_status,
    output logic                        o_runway1_valid,
    output logic [FLIGHT_BITS-1:0]      o_runway1_tag,
    output logic [TIME_BITS-1:0]        o_runway1_wait,
    output logic                        o_runway2_valid,
    output logic                        o_runway2_is_landing,
    output logic [FLIGHT_BITS-1:0]      o_runway2_tag,
    output logic [TIME_BITS-1:0]        o_runway2_wait,
    output logic                        o_emergency_flag,
    output logic [COUNT_W-1:0]          o_landing_count,
    output logic [COUNT_W-1:0]          o_takeoff_count,
    output logic [OUT_CNT_W-1:0]        o_counter_value
);

    localparam int FILL_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W      = (FILL_W > LIMIT_W) ? FILL_W : LIMIT_W;
    localparam int ENTRY_BITS = TAG_BITS + TIME_BITS;

    t_state                  r_state, n_state;
    logic                    r_emerg, n_emerg;
    logic [LIMIT_W-1:0]      r_limit;
    t_req                    r_req;
    logic [FLIGHT_BITS-1:0]  r_tag;
    logic [TIME_BITS-1:0]    r_time;
    logic [SEL_W-1:0]        r_sel;
    logic                    r_hold_valid, n_hold_valid;
    logic [FLIGHT_BITS-1:0]  r_hold_tag, n_hold_tag;
    logic [TIME_BITS-1:0]    r_hold_wait, n_hold_wait;
    t_result                 r_res, n_res;
    logic                    r_out_valid;
    logic                    res_load;
    logic [COUNTER_BITS-1:0] r_cnt [NUM_CNT];
    logic [COUNTER_BITS-1:0] n_cnt [NUM_CNT];
    logic [NUM_CNT-1:0]      cnt_inc;
    logic                    add_land_en;
    logic                    add_takeoff_en;

    t_fifo_cmd               l_cmd, t_cmd;
    logic [ENTRY_BITS-1:0]   l_rd, t_rd;
    logic [FILL_W-1:0]       l_fill, t_fill;
    logic [FILL_W-1:0]       l_after, t_after;
    logic [ENTRY_BITS-1:0]   wdata;
    logic [TIME_BITS-1:0]    wait_l, wait_t;
    logic [FLIGHT_BITS-1:0]  tag_l, tag_t;
    logic                    l_full, t_full, slot_free;

    trqs_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ENTRY_BITS  (ENTRY_BITS)
    ) u_land_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (l_cmd),
        .i_wdata (wdata),
        .o_rdata (l_rd),
        .o_fill  (l_fill)
    );

    trqs_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ENTRY_BITS  (ENTRY_BITS)
    ) u_takeoff_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (t_cmd),
        .i_wdata (wdata),
        .o_rdata (t_rd),
        .o_fill  (t_fill)
    );

    assign wdata  = {TAG_BITS'(r_tag), r_time};
    assign wait_l = r_time - l_rd[TIME_BITS-1:0];
    assign wait_t = r_time - t_rd[TIME_BITS-1:0];
    assign tag_l  = FLIGHT_BITS'(l_rd[ENTRY_BITS-1:TIME_BITS]);
    assign tag_t  = FLIGHT_BITS'(t_rd[ENTRY_BITS-1:TIME_BITS]);

    // A queue is full at the written limit or at the memory depth, whichever is lower.
    assign l_full = (CMP_W'(l_fill) >= CMP_W'(r_limit)) || (l_fill == FILL_W'(QUEUE_DEPTH));
    assign t_full = (CMP_W'(t_fill) >= CMP_W'(r_limit)) || (t_fill == FILL_W'(QUEUE_DEPTH));

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state        = r_state;
        n_emerg        = r_emerg;
        n_hold_valid   = r_hold_valid;
        n_hold_tag     = r_hold_tag;
        n_hold_wait    = r_hold_wait;
        l_cmd          = '0;
        t_cmd          = '0;
        cnt_inc        = '0;
        add_land_en    = 1'b0;
        add_takeoff_en = 1'b0;
        res_load       = 1'b0;
        n_res          = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (slot_free) begin
                    case (r_req)
                        REQ_LAND: begin
                            cnt_inc[CNT_LAND_REQ] = 1'b1;
                            if (!l_full) begin
                                l_cmd.push            = 1'b1;
                                cnt_inc[CNT_LAND_ACC] = 1'b1;
                                n_res.status          = ST_ACCEPTED;
                            end else begin
                                cnt_inc[CNT_LAND_REF] = 1'b1;
                                n_res.status          = ST_REFUSED;
                            end
                            res_load = 1'b1;
                            n_state  = S_IDLE;
                        end
                        REQ_TAKEOFF: begin
                            cnt_inc[CNT_TAKEOFF_REQ] = 1'b1;
                            if (!t_full) begin
                                t_cmd.push               = 1'b1;
                                cnt_inc[CNT_TAKEOFF_ACC] = 1'b1;
                                n_res.status             = ST_ACCEPTED;
                            end else begin
                                cnt_inc[CNT_TAKEOFF_REF] = 1'b1;
                                n_res.status             = ST_REFUSED;
                            end
                            res_load = 1'b1;
                            n_state  = S_IDLE;
                        end
                        REQ_TICK: begin
                            n_res.status = ST_TICK;
                            n_emerg      = r_emerg || l_full;
                            if (l_fill != '0) begin
                                l_cmd.pop             = 1'b1;
                                add_land_en           = 1'b1;
                                cnt_inc[CNT_LANDINGS] = 1'b1;
                                n_res.r1_valid        = 1'b1;
                                n_res.r1_tag          = tag_l;
                                n_res.r1_wait         = wait_l;
                            end else begin
                                cnt_inc[CNT_LAND_IDLE] = 1'b1;
                            end
                            if (n_emerg) begin
                                // The second landing is read from the new head next cycle.
                                n_hold_valid = n_res.r1_valid;
                                n_hold_tag   = n_res.r1_tag;
                                n_hold_wait  = n_res.r1_wait;
                                n_state      = S_POP2;
                            end else begin
                                if (t_fill != '0) begin
                                    t_cmd.pop             = 1'b1;
                                    add_takeoff_en        = 1'b1;
                                    cnt_inc[CNT_TAKEOFFS] = 1'b1;
                                    n_res.r2_valid        = 1'b1;
                                    n_res.r2_tag          = tag_t;
                                    n_res.r2_wait         = wait_t;
                                end else begin
                                    cnt_inc[CNT_TAKEOFF_IDLE] = 1'b1;
                                end
                                res_load = 1'b1;
                                n_state  = S_IDLE;
                            end
                        end
                        REQ_READ: begin
                            n_res.status = ST_READ;
                            if (r_sel < SEL_W'(NUM_CNT)) begin
                                n_res.counter_value = OUT_CNT_W'(r_cnt[r_sel]);
                            end
                            res_load = 1'b1;
                            n_state  = S_IDLE;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_POP2: begin
                if (slot_free) begin
                    n_res.status   = ST_TICK;
                    n_res.r1_valid = r_hold_valid;
                    n_res.r1_tag   = r_hold_tag;
                    n_res.r1_wait  = r_hold_wait;
                    if (l_fill != '0) begin
                        l_cmd.pop             = 1'b1;
                        add_land_en           = 1'b1;
                        cnt_inc[CNT_LANDINGS] = 1'b1;
                        n_res.r2_valid        = 1'b1;
                        n_res.r2_is_landing   = 1'b1;
                        n_res.r2_tag          = tag_l;
                        n_res.r2_wait         = wait_l;
                    end else begin
                        cnt_inc[CNT_LAND_IDLE] = 1'b1;
                    end
                    // Emergency mode ends when this tick leaves the landing queue empty.
                    if (l_fill <= FILL_W'(1)) begin
                        n_emerg = 1'b0;
                    end
                    res_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        l_after             = l_fill + FILL_W'(l_cmd.push) - FILL_W'(l_cmd.pop);
        t_after             = t_fill + FILL_W'(t_cmd.push) - FILL_W'(t_cmd.pop);
        n_res.emergency     = n_emerg;
        n_res.landing_count = COUNT_W'(l_after);
        n_res.takeoff_count = COUNT_W'(t_after);
    end

    // Event counters saturate; the two wait sums wrap.
    always_comb begin
        for (int k = 0; k < NUM_CNT; k++) begin
            n_cnt[k] = r_cnt[k];
            if (cnt_inc[k] && (r_cnt[k] != '1)) begin
                n_cnt[k] = r_cnt[k] + COUNTER_BITS'(1);
            end
        end
        if (add_land_en) begin
            n_cnt[CNT_LAND_WAIT] = r_cnt[CNT_LAND_WAIT] + COUNTER_BITS'(wait_l);
        end
        if (add_takeoff_en) begin
            n_cnt[CNT_TAKEOFF_WAIT] = r_cnt[CNT_TAKEOFF_WAIT] + COUNTER_BITS'(wait_t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_emerg     <= 1'b0;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_CNT; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_emerg <= n_emerg;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            for (int k = 0; k < NUM_CNT; k++) begin
                r_cnt[k] <= n_cnt[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_req  <= t_req'(i_req_type);
            r_tag  <= i_flight_tag;
            r_time <= i_time_now;
            r_sel  <= i_counter_select;
        end
        r_hold_valid <= n_hold_valid;
        r_hold_tag   <= n_hold_tag;
        r_hold_wait  <= n_hold_wait;
        if (res_load) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_status             = r_res.status;
    assign o_runway1_valid      = r_res.r1_valid;
    assign o_runway1_tag        = r_res.r1_tag;
    assign o_runway1_wait       = r_res.r1_wait;
    assign o_runway2_valid      = r_res.r2_valid;
    assign o_runway2_is_landing = r_res.r2_is_landing;
    assign o_runway2_tag        = r_res.r2_tag;
    assign o_runway2_wait       = r_res.r2_wait;
    assign o_emergency_flag     = r_res.emergency;
    assign o_landing_count      = r_res.landing_count;
    assign o_takeoff_count      = r_res.takeoff_count;
    assign o_counter_value      = r_res.counter_value;

    // Within an emergency tick the queue may run dry before its second pop.
    `TRQS_ASSERT(a_emerg_has_landings, (r_emerg && (r_state != S_POP2)) |-> (l_fill != '0), "emergency, no landings")
    `TRQS_ASSERT(a_pop2_in_emerg, (r_state == S_POP2) |-> r_emerg, "second pop outside emergency")
    `TRQS_ASSERT_NEXT(a_transfer_starts_exec, i_in_valid && o_in_ready, r_state == S_EXEC, "no execution")

endmodule

`default_nettype wire

>>> test/runway_schedule_checker.sv
// Watches the scheduler's channels, predicts every outcome and compares it with the block.
module runway_schedule_checker
    import trqs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [LIMIT_W-1:0]     i_cfg_data,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [1:0]             i_req_type,
    input  logic [FLIGHT_BITS-1:0] i_flight_tag,
    input  logic [TIME_BITS-1:0]   i_time_now,
    input  logic [SEL_W-1:0]       i_counter_select,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  t_result                i_result,
    output int                     o_fail_count,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LAND_Q    = 0;
    localparam int TAKEOFF_Q = 1;

    logic [FLIGHT_BITS-1:0] slot_tag  [2][QUEUE_DEPTH_DEF];
    logic [TIME_BITS-1:0]   slot_time [2][QUEUE_DEPTH_DEF];
    int                     head [2];
    int                     tail [2];
    int                     fill [2];
    logic                   emergency;
    logic [OUT_CNT_W-1:0]   stats [NUM_CNT];
    logic [LIMIT_W-1:0]     cur_limit;
    t_result                expected_outcomes [$];
    int                     fails;

    function automatic int limit_cap();
        return (cur_limit < QUEUE_DEPTH_DEF) ? int'(cur_limit) : QUEUE_DEPTH_DEF;
    endfunction

    function automatic void log_event(logic [SEL_W-1:0] k);
        if (stats[k] != '1) begin
            stats[k] = stats[k] + 1'b1;
        end
    endfunction

    // Wait sums wrap rather than saturate.
    function automatic void add_wait(logic [SEL_W-1:0] k, logic [TIME_BITS-1:0] w);
        stats[k] = stats[k] + w;
    endfunction

    function automatic bit enqueue_flight(int q, logic [FLIGHT_BITS-1:0] tag,
                                          logic [TIME_BITS-1:0] now);
        if (fill[q] >= limit_cap()) begin
            return 1'b0;
        end
        slot_tag[q][tail[q]]  = tag;
        slot_time[q][tail[q]] = now;
        tail[q] = (tail[q] + 1) % QUEUE_DEPTH_DEF;
        fill[q]++;
        return 1'b1;
    endfunction

    function automatic bit dequeue_flight(int q, output logic [FLIGHT_BITS-1:0] tag,
                                          output logic [TIME_BITS-1:0] when);
        tag  = '0;
        when = '0;
        if (fill[q] == 0) begin
            return 1'b0;
        end
        tag  = slot_tag[q][head[q]];
        when = slot_time[q][head[q]];
        head[q] = (head[q] + 1) % QUEUE_DEPTH_DEF;
        fill[q]--;
        return 1'b1;
    endfunction

    function automatic t_result predict_outcome(t_req req, logic [FLIGHT_BITS-1:0] tag,
                                                logic [TIME_BITS-1:0] now,
                                                logic [SEL_W-1:0] sel);
        t_result                res;
        logic [FLIGHT_BITS-1:0] got_tag;
        logic [TIME_BITS-1:0]   got_time;
        logic [TIME_BITS-1:0]   waited;
        res = '0;
        case (req)
            REQ_LAND: begin
                log_event(CNT_LAND_REQ);
                if (enqueue_flight(LAND_Q, tag, now)) begin
                    log_event(CNT_LAND_ACC);
                    res.status = ST_ACCEPTED;
                end else begin
                    log_event(CNT_LAND_REF);
                    res.status = ST_REFUSED;
                end
            end
            REQ_TAKEOFF: begin
                log_event(CNT_TAKEOFF_REQ);
                if (enqueue_flight(TAKEOFF_Q, tag, now)) begin
                    log_event(CNT_TAKEOFF_ACC);
                    res.status = ST_ACCEPTED;
                end else begin
                    log_event(CNT_TAKEOFF_REF);
                    res.status = ST_REFUSED;
                end
            end
            REQ_TICK: begin
                res.status = ST_TICK;
                if (fill[LAND_Q] >= limit_cap()) begin
                    emergency = 1'b1;
                end
                if (dequeue_flight(LAND_Q, got_tag, got_time)) begin
                    waited = now - got_time;
                    add_wait(CNT_LAND_WAIT, waited);
                    log_event(CNT_LANDINGS);
                    res.r1_valid = 1'b1;
                    res.r1_tag   = got_tag;
                    res.r1_wait  = waited;
                end else begin
                    log_event(CNT_LAND_IDLE);
                end
                // In emergency mode the second runway takes landings as well.
                if (emergency) begin
                    if (dequeue_flight(LAND_Q, got_tag, got_time)) begin
                        waited = now - got_time;
                        add_wait(CNT_LAND_WAIT, waited);
                        log_event(CNT_LANDINGS);
                        res.r2_valid      = 1'b1;
                        res.r2_is_landing = 1'b1;
                        res.r2_tag        = got_tag;
                        res.r2_wait       = waited;
                    end else begin
                        log_event(CNT_LAND_IDLE);
                    end
                    if (fill[LAND_Q] == 0) begin
                        emergency = 1'b0;
                    end
                end else begin
                    if (dequeue_flight(TAKEOFF_Q, got_tag, got_time)) begin
                        waited = now - got_time;
                        add_wait(CNT_TAKEOFF_WAIT, waited);
                        log_event(CNT_TAKEOFFS);
                        res.r2_valid = 1'b1;
                        res.r2_tag   = got_tag;
                        res.r2_wait  = waited;
                    end else begin
                        log_event(CNT_TAKEOFF_IDLE);
                    end
                end
            end
            default: begin
                res.status        = ST_READ;
                res.counter_value = (sel < NUM_CNT) ? stats[sel] : '0;
            end
        endcase
        res.emergency     = emergency;
        res.landing_count = COUNT_W'(fill[LAND_Q]);
        res.takeoff_count = COUNT_W'(fill[TAKEOFF_Q]);
        return res;
    endfunction

    task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, field, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int q = 0; q < 2; q++) begin
                head[q] = 0;
                tail[q] = 0;
                fill[q] = 0;
            end
            for (int k = 0; k < NUM_CNT; k++) begin
                stats[k] = '0;
            end
            emergency = 1'b0;
            cur_limit = LIMIT_RESET;
            expected_outcomes.delete();
            fails = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_outcomes.size() == 0) begin
                    $display("%0t: result transfer with no outcome expected", $time);
                    fails++;
                end else begin
                    want = expected_outcomes.pop_front();
                    compare_field("status", want.status, i_result.status);
                    compare_field("runway1_valid", want.r1_valid, i_result.r1_valid);
                    compare_field("runway1_tag", want.r1_tag, i_result.r1_tag);
                    compare_field("runway1_wait", want.r1_wait, i_result.r1_wait);
                    compare_field("runway2_valid", want.r2_valid, i_result.r2_valid);
                    compare_field("runway2_is_landing", want.r2_is_landing,
                                  i_result.r2_is_landing);
                    compare_field("runway2_tag", want.r2_tag, i_result.r2_tag);
                    compare_field("runway2_wait", want.r2_wait, i_result.r2_wait);
                    compare_field("emergency_flag", want.emergency, i_result.emergency);
                    compare_field("landing_count", want.landing_count,
                                  i_result.landing_count);
                    compare_field("takeoff_count", want.takeoff_count,
                                  i_result.takeoff_count);
                    compare_field("counter_value", want.counter_value,
                                  i_result.counter_value);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                cur_limit = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                expected_outcomes.push_back(predict_outcome(t_req'(i_req_type), i_flight_tag,
                                                            i_time_now, i_counter_select));
            end
        end
        // Registered so that the stimulus sees a settled value at each edge.
        o_fail_count <= fails;
        o_pending    <= expected_outcomes.size();
    end

endmodule

>>> test/two_runway_queue_scheduler_tb.sv
// Stimulus and verdict for the two-runway queue scheduler, checked by runway_schedule_checker.
module two_runway_queue_scheduler_tb
    import trqs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;

    logic                   i_clk            = 1'b0;
    logic                   i_rst_n          = 1'b0;
    logic                   i_cfg_valid      = 1'b0;
    logic [LIMIT_W-1:0]     i_cfg_data       = '0;
    logic                   i_in_valid       = 1'b0;
    logic [1:0]             i_req_type       = '0;
    logic [FLIGHT_BITS-1:0] i_flight_tag     = '0;
    logic [TIME_BITS-1:0]   i_time_now       = '0;
    logic [SEL_W-1:0]       i_counter_select = '0;
    logic                   i_out_ready      = 1'b0;

    logic                   o_cfg_ready;
    logic                   o_in_ready;
    logic                   o_out_valid;
    logic [1:0]             o_status;
    logic                   o_runway1_valid;
    logic [FLIGHT_BITS-1:0] o_runway1_tag;
    logic [TIME_BITS-1:0]   o_runway1_wait;
    logic                   o_runway2_valid;
    logic                   o_runway2_is_landing;
    logic [FLIGHT_BITS-1:0] o_runway2_tag;
    logic [TIME_BITS-1:0]   o_runway2_wait;
    logic                   o_emergency_flag;
    logic [COUNT_W-1:0]     o_landing_count;
    logic [COUNT_W-1:0]     o_takeoff_count;
    logic [OUT_CNT_W-1:0]   o_counter_value;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;

    two_runway_queue_scheduler u_top (.*);

    runway_schedule_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_req_type       (i_req_type),
        .i_flight_tag     (i_flight_tag),
        .i_time_now       (i_time_now),
        .i_counter_select (i_counter_select),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_result         ({o_status, o_runway1_valid, o_runway1_tag, o_runway1_wait,
                            o_runway2_valid, o_runway2_is_landing, o_runway2_tag,
                            o_runway2_wait, o_emergency_flag, o_landing_count,
                            o_takeoff_count, o_counter_value}),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_request(t_req req, logic [FLIGHT_BITS-1:0] tag,
                                logic [TIME_BITS-1:0] now, logic [SEL_W-1:0] sel);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_req_type       <= req;
        i_flight_tag     <= tag;
        i_time_now       <= now;
        i_counter_select <= sel;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // The first edge lets the checker count the transfer that has just happened.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_traffic(logic [LIMIT_W-1:0] value, int idle_pct, int stall_pct,
                               int items, int land_w, int takeoff_w, int tick_w);
        int   roll;
        t_req req;
        write_limit(value);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < items; n++) begin
            // Halfway through, hold off until the block has emptied its pipeline.
            if (n == items / 2) begin
                wait_drained();
            end
            roll = $urandom_range(0, 99);
            if (roll < land_w) begin
                req = REQ_LAND;
            end else if (roll < land_w + takeoff_w) begin
                req = REQ_TAKEOFF;
            end else if (roll < land_w + takeoff_w + tick_w) begin
                req = REQ_TICK;
            end else begin
                req = REQ_READ;
            end
            send_request(req, FLIGHT_BITS'($urandom()), $urandom(), SEL_W'($urandom_range(0, 15)));
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values, an unknown counter and an idle tick on empty queues.
        send_request(REQ_READ, 16'h0000, 32'h0, CNT_LAND_REQ);
        send_request(REQ_READ, 16'hFFFF, 32'hFFFF_FFFF, 4'hF);
        send_request(REQ_TICK, 16'h0000, 32'h0, 4'h0);
        send_request(REQ_LAND, 16'h0000, 32'hFFFF_FFFF, 4'h0);
        send_request(REQ_LAND, 16'hFFFF, 32'h0, 4'hF);
        send_request(REQ_TAKEOFF, 16'hFFFF, 32'hFFFF_FFFF, 4'h0);
        send_request(REQ_TAKEOFF, 16'h0000, 32'h5, 4'h0);
        // Tick at time zero: the waits wrap round.
        send_request(REQ_TICK, 16'h0000, 32'h0, 4'h0);
        send_request(REQ_READ, 16'h0000, 32'h0, CNT_LAND_WAIT);

        // With a zero limit everything is refused and each tick enters and leaves emergency.
        write_limit(5'd0);
        send_request(REQ_LAND, 16'h1234, 32'h10, 4'h0);
        send_request(REQ_TAKEOFF, 16'h4321, 32'h11, 4'h0);
        send_request(REQ_TICK, 16'h0000, 32'h12, 4'h0);
        send_request(REQ_TICK, 16'h0000, 32'h13, 4'h0);

        // Fill three landings, then lower the limit below the fill.
        write_limit(5'd4);
        send_request(REQ_LAND, 16'hA001, 32'h20, 4'h0);
        send_request(REQ_LAND, 16'hA002, 32'h21, 4'h0);
        send_request(REQ_LAND, 16'hA003, 32'h22, 4'h0);
        write_limit(5'd1);
        send_request(REQ_LAND, 16'hA004, 32'h23, 4'h0);
        send_request(REQ_TICK, 16'h0000, 32'h30, 4'h0);
        send_request(REQ_TAKEOFF, 16'hB001, 32'h31, 4'h0);
        send_request(REQ_TICK, 16'h0000, 32'h40, 4'h0);
        send_request(REQ_READ, 16'h0000, 32'h0, CNT_LAND_IDLE);
        send_request(REQ_READ, 16'h0000, 32'h0, CNT_TAKEOFF_IDLE);

        run_traffic(5'd16, 0, 0, 90, 40, 25, 25);
        run_traffic(5'd4, 79, 0, 70, 35, 30, 25);
        run_traffic(5'd31, 0, 79, 90, 50, 20, 22);
        run_traffic(5'd1, 6, 6, 60, 30, 30, 30);
        run_traffic(5'd0, 79, 79, 40, 35, 35, 20);
        run_traffic(5'd9, 0, 0, 80, 40, 25, 25);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/trqs_pkg.sv
sv/trqs_fifo.sv
sv/two_runway_queue_scheduler.sv
test/runway_schedule_checker.sv
test/two_runway_queue_scheduler_tb.sv
